// File: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the source text tokenizer
// Item structs, token kinds, error codes, character codes and keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [9:0]  token_length;
    logic [2:0]  error_code;
    logic [7:0]  bad_byte;
    logic        last_of_run;
  } out_item_t;

  // token kinds
  localparam logic [5:0] K_NUMBER = 6'd0;
  localparam logic [5:0] K_STRING = 6'd1;
  localparam logic [5:0] K_PLUS   = 6'd2;
  localparam logic [5:0] K_MINUS  = 6'd3;
  localparam logic [5:0] K_MUL    = 6'd4;
  localparam logic [5:0] K_DIV    = 6'd5;
  localparam logic [5:0] K_LPAREN = 6'd6;
  localparam logic [5:0] K_RPAREN = 6'd7;
  localparam logic [5:0] K_IDENT  = 6'd8;
  localparam logic [5:0] K_TYPE   = 6'd9;
  localparam logic [5:0] K_PIPE   = 6'd10;
  localparam logic [5:0] K_LBRACE = 6'd11;
  localparam logic [5:0] K_RBRACE = 6'd12;
  localparam logic [5:0] K_NUMKW  = 6'd13;
  localparam logic [5:0] K_STRKW  = 6'd14;
  localparam logic [5:0] K_FUN    = 6'd15;
  localparam logic [5:0] K_LET    = 6'd16;
  localparam logic [5:0] K_IN     = 6'd17;
  localparam logic [5:0] K_END    = 6'd18;
  localparam logic [5:0] K_IF     = 6'd19;
  localparam logic [5:0] K_THEN   = 6'd20;
  localparam logic [5:0] K_ELSE   = 6'd21;
  localparam logic [5:0] K_EQEQ   = 6'd22;
  localparam logic [5:0] K_NE     = 6'd23;
  localparam logic [5:0] K_LT     = 6'd24;
  localparam logic [5:0] K_LE     = 6'd25;
  localparam logic [5:0] K_GT     = 6'd26;
  localparam logic [5:0] K_GE     = 6'd27;
  localparam logic [5:0] K_ARROW  = 6'd28;
  localparam logic [5:0] K_COMMA  = 6'd29;
  localparam logic [5:0] K_SEMI   = 6'd30;
  localparam logic [5:0] K_EQUAL  = 6'd31;
  localparam logic [5:0] K_EOF    = 6'd32;
  localparam logic [5:0] K_ERROR  = 6'd33;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_BANG    = 3'd2;
  localparam logic [2:0] ERR_UNTERM  = 3'd3;
  localparam logic [2:0] ERR_LONG    = 3'd4;

  // character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // keyword table: text right-justified in the low bytes, first char highest
  localparam int KW_COUNT = 10;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'("type"), 48'("Number"), 48'("String"), 48'("fun"), 48'("let"),
    48'("in"), 48'("end"), 48'("if"), 48'("then"), 48'("else")
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd6, 3'd6, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd4
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    K_TYPE, K_NUMKW, K_STRKW, K_FUN, K_LET, K_IN, K_END, K_IF, K_THEN, K_ELSE
  };

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  // prefix holds byte i of the word at bits [8i+7:8i]; len 7 means "longer than 6"
  function automatic logic [5:0] word_kind(logic [47:0] prefix, logic [2:0] len);
    logic [5:0] kind;
    logic       hit;
    kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (len == KW_LEN[k]);
      for (int i = 0; i < 6; i++) begin
        if (i < int'(KW_LEN[k])) begin
          hit = hit && (prefix[8*i +: 8] == KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]);
        end
      end
      if (hit) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

  function automatic out_item_t mk_item(logic [5:0] kind, logic [31:0] start,
                                        logic [9:0] len, logic [2:0] err,
                                        logic [7:0] bad);
    out_item_t r;
    r.token_kind   = kind;
    r.token_start  = start;
    r.token_length = len;
    r.error_code   = err;
    r.bad_byte     = bad;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-stream lexer
// Turns a stream of text bytes into tokens with kind, start offset and length.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per text byte; an item with end_of_text set closes the
//           text (its byte is ignored) and yields the pending token and eof.
//   out_* : token items; up to two per input item, last_of_run marks the
//           final one caused by an input item.
//   Latency: an input item's tokens are visible on out_* the cycle after it
//   is accepted (behind any tokens still waiting in the output queue).
//   Throughput: one input item per cycle while each item makes at most one
//   token and out_ready is high; an item that ends one token and emits
//   another puts two tokens in the queue. The 3-entry output queue sets
//   this: input is taken while it holds at most one token.
//   Reset (rst_n low, synchronous) clears the scanner to idle, the text
//   position to zero and empties the output queue.
//   Stall: while out_ready is low tokens stay in the queue and in_ready
//   drops once two are waiting; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
  parameter int MAX_WORD_LEN   = 63,
  parameter int MAX_STRING_LEN = 1023,
  parameter int POSITION_BITS  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stt_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stt_pkg::out_item_t      out_item
);

  localparam int LEN_MAX  = (MAX_STRING_LEN > MAX_WORD_LEN) ? MAX_STRING_LEN : MAX_WORD_LEN;
  localparam int LEN_BITS = $clog2(LEN_MAX + 1);
  localparam logic [LEN_BITS-1:0] MAXW_L = LEN_BITS'(MAX_WORD_LEN);
  localparam logic [LEN_BITS-1:0] MAXS_L = LEN_BITS'(MAX_STRING_LEN);
  // error lengths, masked to the 10-bit length field
  localparam logic [9:0] MAXW_10 = 10'(MAX_WORD_LEN % 1024);
  localparam logic [9:0] MAXS_10 = 10'(MAX_STRING_LEN % 1024);
  localparam int QDEPTH = 3;

  typedef enum logic [3:0] {
    M_IDLE, M_NUMBER, M_IDENT, M_STRING, M_MINUS, M_EQ, M_BANG, M_LT, M_GT, M_DROP
  } mode_t;

  // scanner state
  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LEN_BITS-1:0]      len_r, len_nxt;
  logic [47:0]              prefix_r, prefix_nxt;

  // output queue, entry 0 is the head
  stt_pkg::out_item_t q_r [QDEPTH];
  stt_pkg::out_item_t q_nxt [QDEPTH];
  logic [1:0]         cnt_r, cnt_nxt;

  logic in_fire, pop;
  logic [7:0] b;

  // field views of the state at result widths
  logic [POSITION_BITS+31:0] pos_ext, start_ext;
  logic [LEN_BITS+9:0]       len_ext;
  logic [31:0]               pos32, start32;
  logic [9:0]                len10;
  logic [2:0]                kw_len;

  // pending token flushed when a byte ends it
  logic               fl_v;
  stt_pkg::out_item_t fl_item;
  // result from the current mode, result from starting a new lexeme
  logic               a_v, s_v, do_start;
  stt_pkg::out_item_t a_item, s_item;
  logic [1:0]         n_res;
  logic [1:0]         base;
  stt_pkg::out_item_t r0, r1;

  assign b         = in_item.text_byte;
  assign in_ready  = (cnt_r < 2'd2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = q_r[0];
  assign pop       = out_valid && out_ready;

  assign pos_ext   = {32'b0, pos_r};
  assign start_ext = {32'b0, start_r};
  assign len_ext   = {10'b0, len_r};
  assign pos32     = pos_ext[31:0];
  assign start32   = start_ext[31:0];
  assign len10     = len_ext[9:0];
  assign kw_len    = (len_r <= LEN_BITS'(6)) ? len_r[2:0] : 3'd7;

  always_comb begin
    fl_v    = 1'b1;
    fl_item = stt_pkg::mk_item(stt_pkg::K_NUMBER, start32, len10, stt_pkg::ERR_NONE, 8'd0);
    unique case (mode_r)
      M_NUMBER: ;
      M_IDENT:  fl_item.token_kind = stt_pkg::word_kind(prefix_r, kw_len);
      M_MINUS: begin
        fl_item.token_kind   = stt_pkg::K_MINUS;
        fl_item.token_length = 10'd1;
      end
      M_EQ: begin
        fl_item.token_kind   = stt_pkg::K_EQUAL;
        fl_item.token_length = 10'd1;
      end
      M_LT: begin
        fl_item.token_kind   = stt_pkg::K_LT;
        fl_item.token_length = 10'd1;
      end
      M_GT: begin
        fl_item.token_kind   = stt_pkg::K_GT;
        fl_item.token_length = 10'd1;
      end
      default: fl_v = 1'b0;
    endcase
  end

  // next scanner state and the (up to two) results of this item
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    a_v        = 1'b0;
    a_item     = fl_item;
    s_v        = 1'b0;
    s_item     = fl_item;
    do_start   = 1'b0;

    if (in_item.end_of_text) begin
      // pending token (or open-string / bang error), then eof; back to reset
      if (mode_r == M_STRING) begin
        a_v    = 1'b1;
        a_item = stt_pkg::mk_item(stt_pkg::K_ERROR, start32, len10,
                                  stt_pkg::ERR_UNTERM, 8'd0);
      end else if (mode_r == M_BANG) begin
        a_v    = 1'b1;
        a_item = stt_pkg::mk_item(stt_pkg::K_ERROR, start32, 10'd1,
                                  stt_pkg::ERR_BANG, 8'd0);
      end else begin
        a_v = fl_v;
      end
      s_v        = 1'b1;
      s_item     = stt_pkg::mk_item(stt_pkg::K_EOF, pos32, 10'd0, stt_pkg::ERR_NONE, 8'd0);
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      start_nxt  = '0;
      len_nxt    = '0;
      prefix_nxt = '0;
    end else begin
      pos_nxt = pos_r + POSITION_BITS'(1);
      unique case (mode_r)
        M_IDLE: do_start = 1'b1;
        M_NUMBER, M_IDENT: begin
          if ((mode_r == M_NUMBER) ? (stt_pkg::is_digit(b) || b == stt_pkg::CH_DOT)
                                   : stt_pkg::is_word(b)) begin
            if (len_r >= MAXW_L) begin
              a_v      = 1'b1;
              a_item   = stt_pkg::mk_item(stt_pkg::K_ERROR, start32, MAXW_10,
                                          stt_pkg::ERR_LONG, 8'd0);
              mode_nxt = M_DROP;
            end else begin
              if (mode_r == M_IDENT && len_r < LEN_BITS'(6)) begin
                prefix_nxt = prefix_r | (48'(b) << {len_r[2:0], 3'b000});
              end
              len_nxt = len_r + LEN_BITS'(1);
            end
          end else begin
            a_v      = 1'b1;
            do_start = 1'b1;
          end
        end
        M_STRING: begin
          if (b == stt_pkg::CH_QUOTE) begin
            a_v      = 1'b1;
            a_item   = stt_pkg::mk_item(stt_pkg::K_STRING, start32, len10,
                                        stt_pkg::ERR_NONE, 8'd0);
            mode_nxt = M_IDLE;
          end else if (len_r >= MAXS_L) begin
            a_v      = 1'b1;
            a_item   = stt_pkg::mk_item(stt_pkg::K_ERROR, start32, MAXS_10,
                                        stt_pkg::ERR_LONG, 8'd0);
            mode_nxt = M_DROP;
          end else begin
            len_nxt = len_r + LEN_BITS'(1);
          end
        end
        M_BANG: begin
          a_v = 1'b1;
          if (b == stt_pkg::CH_EQUAL) begin
            a_item   = stt_pkg::mk_item(stt_pkg::K_NE, start32, 10'd2,
                                        stt_pkg::ERR_NONE, 8'd0);
            mode_nxt = M_IDLE;
          end else begin
            a_item   = stt_pkg::mk_item(stt_pkg::K_ERROR, start32, 10'd1,
                                        stt_pkg::ERR_BANG, 8'd0);
            mode_nxt = M_DROP;
          end
        end
        M_MINUS, M_EQ, M_LT, M_GT: begin
          a_v = 1'b1;
          if (mode_r == M_MINUS && b == stt_pkg::CH_GT) begin
            a_item   = stt_pkg::mk_item(stt_pkg::K_ARROW, start32, 10'd2,
                                        stt_pkg::ERR_NONE, 8'd0);
            mode_nxt = M_IDLE;
          end else if (mode_r != M_MINUS && b == stt_pkg::CH_EQUAL) begin
            a_item = stt_pkg::mk_item(stt_pkg::K_EQEQ, start32, 10'd2,
                                      stt_pkg::ERR_NONE, 8'd0);
            if (mode_r == M_LT) a_item.token_kind = stt_pkg::K_LE;
            if (mode_r == M_GT) a_item.token_kind = stt_pkg::K_GE;
            mode_nxt = M_IDLE;
          end else begin
            do_start = 1'b1;  // flush the one-char operator, rescan byte
          end
        end
        default: mode_nxt = M_DROP;
      endcase

      if (do_start) begin
        start_nxt = pos_r;
        len_nxt   = LEN_BITS'(1);
        mode_nxt  = M_IDLE;
        s_item    = stt_pkg::mk_item(stt_pkg::K_PLUS, pos32, 10'd1, stt_pkg::ERR_NONE, 8'd0);
        case (b)
          stt_pkg::CH_PLUS:   s_v = 1'b1;
          stt_pkg::CH_STAR:   begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_MUL;    end
          stt_pkg::CH_SLASH:  begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_DIV;    end
          stt_pkg::CH_LPAREN: begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_LPAREN; end
          stt_pkg::CH_RPAREN: begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_RPAREN; end
          stt_pkg::CH_PIPE:   begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_PIPE;   end
          stt_pkg::CH_LBRACE: begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_LBRACE; end
          stt_pkg::CH_RBRACE: begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_RBRACE; end
          stt_pkg::CH_COMMA:  begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_COMMA;  end
          stt_pkg::CH_SEMI:   begin s_v = 1'b1; s_item.token_kind = stt_pkg::K_SEMI;   end
          stt_pkg::CH_MINUS:  mode_nxt = M_MINUS;
          stt_pkg::CH_EQUAL:  mode_nxt = M_EQ;
          stt_pkg::CH_BANG:   mode_nxt = M_BANG;
          stt_pkg::CH_LT:     mode_nxt = M_LT;
          stt_pkg::CH_GT:     mode_nxt = M_GT;
          stt_pkg::CH_QUOTE: begin
            // strings report their content, which starts after the quote
            mode_nxt  = M_STRING;
            start_nxt = pos_r + POSITION_BITS'(1);
            len_nxt   = '0;
          end
          default: begin
            if (stt_pkg::is_space(b)) begin
              mode_nxt = M_IDLE;
            end else if (stt_pkg::is_digit(b) || b == stt_pkg::CH_DOT) begin
              mode_nxt = M_NUMBER;
            end else if (stt_pkg::is_alpha(b) || b == stt_pkg::CH_UNDER) begin
              mode_nxt   = M_IDENT;
              prefix_nxt = {40'b0, b};
            end else begin
              s_v      = 1'b1;
              s_item   = stt_pkg::mk_item(stt_pkg::K_ERROR, pos32, 10'd1,
                                          stt_pkg::ERR_UNKNOWN, b);
              mode_nxt = M_DROP;
            end
          end
        endcase
      end
    end
  end

  // pack the results in order and mark the last one
  always_comb begin
    r0    = a_v ? a_item : s_item;
    r1    = s_item;
    n_res = in_fire ? (2'(a_v) + 2'(s_v)) : 2'd0;
    if (n_res == 2'd1) r0.last_of_run = 1'b1;
    r1.last_of_run = 1'b1;
  end

  // queue update: shift out the head, then append at the fill point
  always_comb begin
    base = cnt_r - 2'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = (pop && i < QDEPTH - 1) ? q_r[(i + 1) % QDEPTH] : q_r[i];
      if (n_res != 2'd0 && 2'(i) == base) q_nxt[i] = r0;
      if (n_res == 2'd2 && 2'(i) == base + 2'd1) q_nxt[i] = r1;
    end
    cnt_nxt = base + n_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
      cnt_r    <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        start_r  <= start_nxt;
        len_r    <= len_nxt;
        prefix_r <= prefix_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

`default_nettype wire

// File: sv/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker: port-level checks for the source text tokenizer
// Watches the token channel for consistent error fields and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire stt_pkg::out_item_t out_item
);

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("token changed while stalled");

  // eof always closes the run of its end item
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.token_kind == stt_pkg::K_EOF |-> out_item.last_of_run)
    else $error("eof token not marked last");

  // error kind and error code agree
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.token_kind == stt_pkg::K_ERROR) ==
                   (out_item.error_code != stt_pkg::ERR_NONE)))
    else $error("error code does not match token kind");

  // bad byte only reported for unknown-byte errors
  a_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.bad_byte != 8'd0 |-> out_item.error_code == stt_pkg::ERR_UNKNOWN)
    else $error("bad byte set on a non-unknown token");

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("tokens left after reset");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire

// File: verif/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: self-checking bench for the byte-stream lexer
// Feeds short directed texts, then generated texts built mostly from valid
// lexemes (with occasional errors), in three idle/stall phases. A local
// token predictor tracks the scanner and every output item is checked
// field by field against the oldest predicted token.
// ----------------------------------------------------------------------------

module source_text_tokenizer_tb;

  localparam int WORD_LIMIT   = 63;
  localparam int STRING_LIMIT = 1023;
  localparam int RANDOM_ITEMS = 690;
  localparam int DRAIN_CYCLES = 8;        // block answers the cycle after accept
  localparam int CYCLE_LIMIT  = 400000;   // far above the slowest legal run
  localparam int PRINT_LIMIT  = 100;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_STRING, MODE_MINUS,
    MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_DROP
  } scan_mode_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  stt_pkg::in_item_t   in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  stt_pkg::out_item_t  out_item;

  source_text_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stimulus items not yet driven, and tokens predicted but not yet seen
  stt_pkg::in_item_t    text_feed [$];
  stt_pkg::out_item_t   expected_tokens [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          mismatch_count = 0;
  int          token_count = 0;
  int          text_items = 0;
  int          cycle_count = 0;

  // --------------------------------------------------------------------------
  // Token predictor: a local copy of the scanner state
  // --------------------------------------------------------------------------
  scan_mode_t          sc_mode;
  logic [31:0]         sc_pos;
  logic [31:0]         sc_start;
  logic [9:0]          sc_len;
  logic [47:0]         sc_prefix;
  stt_pkg::out_item_t  run_buf [2];
  int                  run_n;

  function automatic logic is_dec(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return b == stt_pkg::CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_word_char(logic [7:0] b);
    return is_letter(b) || is_dec(b) || b == stt_pkg::CH_UNDER;
  endfunction

  function automatic string kw_name(int k);
    case (k)
      0: return "type";
      1: return "Number";
      2: return "String";
      3: return "fun";
      4: return "let";
      5: return "in";
      6: return "end";
      7: return "if";
      8: return "then";
      default: return "else";
    endcase
  endfunction

  function automatic logic [5:0] kw_token(int k);
    case (k)
      0: return stt_pkg::K_TYPE;
      1: return stt_pkg::K_NUMKW;
      2: return stt_pkg::K_STRKW;
      3: return stt_pkg::K_FUN;
      4: return stt_pkg::K_LET;
      5: return stt_pkg::K_IN;
      6: return stt_pkg::K_END;
      7: return stt_pkg::K_IF;
      8: return stt_pkg::K_THEN;
      default: return stt_pkg::K_ELSE;
    endcase
  endfunction

  // prefix keeps byte i of the word at bits [8i+7:8i]; only the first
  // min(length, 6) bytes are meaningful
  function automatic logic [5:0] word_token();
    string       w;
    logic [47:0] want;
    logic [47:0] mask;
    for (int k = 0; k < 10; k++) begin
      w = kw_name(k);
      want = '0;
      mask = '0;
      for (int i = 0; i < w.len(); i++) begin
        want[8*i +: 8] = w[i];
        mask[8*i +: 8] = 8'hFF;
      end
      if (int'(sc_len) == w.len() && (sc_prefix & mask) == want) return kw_token(k);
    end
    return stt_pkg::K_IDENT;
  endfunction

  function automatic void put_token(logic [5:0] kind, logic [31:0] start, logic [9:0] len,
                                    logic [2:0] err, logic [7:0] bad);
    if (run_n < 2) begin
      run_buf[run_n].token_kind   = kind;
      run_buf[run_n].token_start  = start;
      run_buf[run_n].token_length = len;
      run_buf[run_n].error_code   = err;
      run_buf[run_n].bad_byte     = bad;
      run_buf[run_n].last_of_run  = 1'b0;
      run_n++;
    end
  endfunction

  function automatic void raise_error(logic [2:0] code, logic [31:0] start, logic [9:0] len,
                                      logic [7:0] bad);
    put_token(stt_pkg::K_ERROR, start, len, code, bad);
    sc_mode = MODE_DROP;
  endfunction

  function automatic void clear_scanner();
    sc_mode   = MODE_IDLE;
    sc_pos    = '0;
    sc_start  = '0;
    sc_len    = '0;
    sc_prefix = '0;
  endfunction

  // first byte of a lexeme, scanner idle
  function automatic void begin_token(logic [7:0] b, logic [31:0] p);
    logic [5:0] single;
    logic       has_single;
    has_single = 1'b1;
    single     = stt_pkg::K_ERROR;
    sc_start   = p;
    sc_len     = 10'd1;
    case (b)
      stt_pkg::CH_PLUS:   single = stt_pkg::K_PLUS;
      stt_pkg::CH_STAR:   single = stt_pkg::K_MUL;
      stt_pkg::CH_SLASH:  single = stt_pkg::K_DIV;
      stt_pkg::CH_LPAREN: single = stt_pkg::K_LPAREN;
      stt_pkg::CH_RPAREN: single = stt_pkg::K_RPAREN;
      stt_pkg::CH_PIPE:   single = stt_pkg::K_PIPE;
      stt_pkg::CH_LBRACE: single = stt_pkg::K_LBRACE;
      stt_pkg::CH_RBRACE: single = stt_pkg::K_RBRACE;
      stt_pkg::CH_COMMA:  single = stt_pkg::K_COMMA;
      stt_pkg::CH_SEMI:   single = stt_pkg::K_SEMI;
      stt_pkg::CH_MINUS: begin sc_mode = MODE_MINUS; return; end
      stt_pkg::CH_EQUAL: begin sc_mode = MODE_EQ;    return; end
      stt_pkg::CH_BANG:  begin sc_mode = MODE_BANG;  return; end
      stt_pkg::CH_LT:    begin sc_mode = MODE_LT;    return; end
      stt_pkg::CH_GT:    begin sc_mode = MODE_GT;    return; end
      stt_pkg::CH_QUOTE: begin
        // strings report their content, which starts after the quote
        sc_mode  = MODE_STRING;
        sc_start = p + 32'd1;
        sc_len   = '0;
        return;
      end
      default: has_single = 1'b0;
    endcase
    if (has_single) begin
      put_token(single, p, 10'd1, stt_pkg::ERR_NONE, 8'd0);
      sc_mode = MODE_IDLE;
    end else if (is_ws(b)) begin
      sc_mode = MODE_IDLE;
    end else if (is_dec(b) || b == stt_pkg::CH_DOT) begin
      sc_mode = MODE_NUMBER;
    end else if (is_letter(b) || b == stt_pkg::CH_UNDER) begin
      sc_mode   = MODE_IDENT;
      sc_prefix = {40'd0, b};
    end else begin
      raise_error(stt_pkg::ERR_UNKNOWN, p, 10'd1, b);
    end
  endfunction

  function automatic void flush_pending();
    case (sc_mode)
      MODE_NUMBER: put_token(stt_pkg::K_NUMBER, sc_start, sc_len, stt_pkg::ERR_NONE, 8'd0);
      MODE_IDENT:  put_token(word_token(), sc_start, sc_len, stt_pkg::ERR_NONE, 8'd0);
      MODE_MINUS:  put_token(stt_pkg::K_MINUS, sc_start, 10'd1, stt_pkg::ERR_NONE, 8'd0);
      MODE_EQ:     put_token(stt_pkg::K_EQUAL, sc_start, 10'd1, stt_pkg::ERR_NONE, 8'd0);
      MODE_LT:     put_token(stt_pkg::K_LT, sc_start, 10'd1, stt_pkg::ERR_NONE, 8'd0);
      MODE_GT:     put_token(stt_pkg::K_GT, sc_start, 10'd1, stt_pkg::ERR_NONE, 8'd0);
      default: ;
    endcase
    sc_mode = MODE_IDLE;
  endfunction

  function automatic void scan_byte(logic [7:0] b, logic [31:0] p);
    logic [5:0] pair;
    logic       paired;
    case (sc_mode)
      MODE_IDLE: begin_token(b, p);
      MODE_NUMBER, MODE_IDENT: begin
        if (sc_mode == MODE_NUMBER ? (is_dec(b) || b == stt_pkg::CH_DOT)
                                   : is_word_char(b)) begin
          if (int'(sc_len) >= WORD_LIMIT) begin
            raise_error(stt_pkg::ERR_LONG, sc_start, 10'(WORD_LIMIT), 8'd0);
          end else begin
            if (sc_mode == MODE_IDENT && sc_len < 10'd6) sc_prefix[8*sc_len +: 8] = b;
            sc_len = sc_len + 10'd1;
          end
        end else begin
          // byte closes the word and is then scanned on its own
          flush_pending();
          begin_token(b, p);
        end
      end
      MODE_STRING: begin
        if (b == stt_pkg::CH_QUOTE) begin
          put_token(stt_pkg::K_STRING, sc_start, sc_len, stt_pkg::ERR_NONE, 8'd0);
          sc_mode = MODE_IDLE;
        end else if (int'(sc_len) >= STRING_LIMIT) begin
          raise_error(stt_pkg::ERR_LONG, sc_start, 10'(STRING_LIMIT), 8'd0);
        end else begin
          sc_len = sc_len + 10'd1;
        end
      end
      MODE_BANG: begin
        if (b == stt_pkg::CH_EQUAL) begin
          put_token(stt_pkg::K_NE, sc_start, 10'd2, stt_pkg::ERR_NONE, 8'd0);
          sc_mode = MODE_IDLE;
        end else begin
          raise_error(stt_pkg::ERR_BANG, sc_start, 10'd1, 8'd0);
        end
      end
      MODE_MINUS, MODE_EQ, MODE_LT, MODE_GT: begin
        paired = 1'b1;
        pair   = stt_pkg::K_ERROR;
        if (sc_mode == MODE_MINUS && b == stt_pkg::CH_GT)      pair = stt_pkg::K_ARROW;
        else if (sc_mode == MODE_EQ && b == stt_pkg::CH_EQUAL) pair = stt_pkg::K_EQEQ;
        else if (sc_mode == MODE_LT && b == stt_pkg::CH_EQUAL) pair = stt_pkg::K_LE;
        else if (sc_mode == MODE_GT && b == stt_pkg::CH_EQUAL) pair = stt_pkg::K_GE;
        else paired = 1'b0;
        if (paired) begin
          put_token(pair, sc_start, 10'd2, stt_pkg::ERR_NONE, 8'd0);
          sc_mode = MODE_IDLE;
        end else begin
          flush_pending();
          begin_token(b, p);
        end
      end
      default: sc_mode = MODE_DROP;   // after an error: drop until end of text
    endcase
  endfunction

  // one accepted input item -> zero, one or two expected tokens
  function automatic void predict_tokens(stt_pkg::in_item_t it);
    run_n = 0;
    if (it.end_of_text) begin
      if (sc_mode == MODE_STRING)
        put_token(stt_pkg::K_ERROR, sc_start, sc_len, stt_pkg::ERR_UNTERM, 8'd0);
      else if (sc_mode == MODE_BANG)
        put_token(stt_pkg::K_ERROR, sc_start, 10'd1, stt_pkg::ERR_BANG, 8'd0);
      else
        flush_pending();
      put_token(stt_pkg::K_EOF, sc_pos, 10'd0, stt_pkg::ERR_NONE, 8'd0);
      clear_scanner();
    end else begin
      scan_byte(it.text_byte, sc_pos);
      sc_pos = sc_pos + 32'd1;
    end
    if (run_n > 0) run_buf[run_n-1].last_of_run = 1'b1;
    for (int i = 0; i < run_n; i++) expected_tokens.push_back(run_buf[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] ERROR %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("token %0d %s: got 0x%0h, expected 0x%0h",
                                token_count, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver: moves the next item onto in_* once the previous one is taken.
  // in_valid only changes when low or at acceptance, so it never drops early.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_tokens(in_item);
      if (!in_valid || in_ready) begin
        if (text_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= text_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: every accepted token against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d: unexpected, kind %0d start %0d",
                                  token_count, out_item.token_kind, out_item.token_start));
      end else begin
        stt_pkg::out_item_t want;
        want = expected_tokens.pop_front();
        check_field("kind",   32'(out_item.token_kind),   32'(want.token_kind));
        check_field("start",  out_item.token_start,       want.token_start);
        check_field("length", 32'(out_item.token_length), 32'(want.token_length));
        check_field("error",  32'(out_item.error_code),   32'(want.error_code));
        check_field("bad",    32'(out_item.bad_byte),     32'(want.bad_byte));
        check_field("last",   32'(out_item.last_of_run),  32'(want.last_of_run));
      end
      token_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("source_text_tokenizer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------
  task automatic push_item(logic [7:0] b, logic eot);
    stt_pkg::in_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    text_feed.push_back(it);
  endtask

  task automatic push_byte(logic [7:0] b);
    push_item(b, 1'b0);
    text_items++;
  endtask

  // byte is ignored with end_of_text set, so it is random
  task automatic push_end();
    push_item(8'($urandom_range(0, 255)), 1'b1);
    text_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_letter();
    return pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_");
  endfunction

  function automatic logic [7:0] rand_word_char();
    return pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789");
  endfunction

  function automatic logic [7:0] rand_num_char();
    return pick("0123456789.");
  endfunction

  function automatic logic [7:0] rand_space();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(9, 13));
    return stt_pkg::CH_SPACE;
  endfunction

  // any byte but the closing quote, 0 and high bytes included
  function automatic logic [7:0] rand_content();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == stt_pkg::CH_QUOTE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic string op_text(int k);
    case (k)
      0:  return "+";
      1:  return "-";
      2:  return "*";
      3:  return "/";
      4:  return "(";
      5:  return ")";
      6:  return "|";
      7:  return "{";
      8:  return "}";
      9:  return ",";
      10: return ";";
      11: return "==";
      12: return "!=";
      13: return "<";
      14: return "<=";
      15: return ">";
      16: return ">=";
      17: return "->";
      default: return "=";
    endcase
  endfunction

  // One text: mostly valid lexemes, glued or space separated, closed by an
  // end item. An error lexeme ends the text early, with a few dropped bytes.
  task automatic gen_text();
    int    n_tok;
    int    sel;
    int    len;
    int    variant;
    string w;
    bit    broken;
    n_tok  = $urandom_range(1, 10);
    broken = 1'b0;
    for (int t = 0; t < n_tok && !broken; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 14) begin
        repeat ($urandom_range(1, 6)) push_byte(rand_num_char());
      end else if (sel < 28) begin
        // keyword, or a near miss: one byte short or one byte too many
        w = kw_name($urandom_range(0, 9));
        variant = $urandom_range(0, 3);
        if (variant == 0) push_text(w.substr(0, w.len() - 2));
        else push_text(w);
        if (variant == 1) push_byte(rand_word_char());
      end else if (sel < 42) begin
        push_byte(rand_letter());
        repeat ($urandom_range(0, 7)) push_byte(rand_word_char());
      end else if (sel < 54) begin
        push_byte(stt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 8)) push_byte(rand_content());
        // sometimes leave the last string open at end of text
        if (!(t == n_tok - 1 && $urandom_range(0, 3) == 0)) push_byte(stt_pkg::CH_QUOTE);
      end else if (sel < 90) begin
        push_text(op_text($urandom_range(0, 18)));
      end else if (sel < 94) begin
        // words around the length limit
        len = $urandom_range(WORD_LIMIT - 3, WORD_LIMIT + 7);
        if ($urandom_range(0, 1)) begin
          repeat (len) push_byte(rand_num_char());
        end else begin
          push_byte(rand_letter());
          repeat (len - 1) push_byte(rand_word_char());
        end
        broken = (len > WORD_LIMIT);
      end else if (sel < 97) begin
        push_byte(8'($urandom_range(0, 255)));
        broken = 1'b1;
      end else begin
        push_byte(stt_pkg::CH_BANG);
        broken = 1'b1;
      end
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) push_byte(rand_space());
    end
    if (broken) repeat ($urandom_range(0, 3)) push_item(8'($urandom_range(0, 255)), 1'b0);
    push_end();
  endtask

  // wait until everything queued was taken and answered, then let the
  // block settle (an item can leave it busy with no token outstanding)
  task automatic wait_drained();
    while (text_feed.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, then three phases of idling; each phase drains fully,
  // so the sender sits still until every predicted token has come back.
  // --------------------------------------------------------------------------
  initial begin
    clear_scanner();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 21; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (ph == 0) begin
        // ident, arrow, number with dot, not-equal, then eof
        push_text("x->1.!=");
        push_end();
        // string left open at end of text
        push_text("\"q");
        push_end();
        // lone bang at end of text
        push_text("!");
        push_end();
        // lone bang followed by a byte, then a dropped 0xFF byte
        push_text("!a");
        push_byte(8'hFF);
        push_end();
        // unknown byte zero
        push_byte(8'h00);
        push_end();
        // each held-back operator ended by a byte that does not pair with it, the last by end of text
        push_text("=<>-");
        push_end();
      end

      if (ph == 1) begin
        // string content runs past the limit: full length is taken, the
        // next content byte raises the error
        push_byte(stt_pkg::CH_QUOTE);
        repeat (STRING_LIMIT + 2) push_byte(rand_content());
        push_end();
      end

      text_items = 0;
      while (text_items < RANDOM_ITEMS / 3) gen_text();
      wait_drained();
    end

    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("source_text_tokenizer: match");
    end else begin
      $display("source_text_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
